FILE: rtl/utf8_to_cp1251_transcoder_assert.svh
// assertion macros for the utf-8 to cp1251 transcoder checker
// no dependencies
`ifndef UTF8_TO_CP1251_TRANSCODER_ASSERT_SVH
`define UTF8_TO_CP1251_TRANSCODER_ASSERT_SVH
// implication checked on every clock, skipped during reset
`define U2C_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("u2c check failed");
// next-cycle implication
`define U2C_ASSERT_NXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("u2c check failed");
`endif

FILE: rtl/u2c_pkg.sv
// shared types and code point mapping for the utf-8 to cp1251 transcoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package u2c_pkg;
  localparam logic [7:0] QmarkByte = 8'h3F;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       from_invalid;
    logic       run_last;
    logic       text_done;
  } u2c_res_t;

  function automatic logic [2:0] seq_length(input logic [7:0] b);
    logic [2:0] l;
    begin
      if (b < 8'h80) l = 3'd1;
      else if (b >= 8'hC2 && b <= 8'hDF) l = 3'd2;
      else if (b >= 8'hE0 && b <= 8'hEF) l = 3'd3;
      else if (b >= 8'hF0 && b <= 8'hF4) l = 3'd4;
      else l = 3'd0;
      return l;
    end
  endfunction

  function automatic logic follow_ok(input logic [7:0] lead, input logic [1:0] pos,
                                     input logic [7:0] b);
    logic [7:0] lo;
    logic [7:0] hi;
    begin
      lo = 8'h80;
      hi = 8'hBF;
      if (pos == 2'd1) begin
        if (lead == 8'hE0) lo = 8'hA0;
        else if (lead == 8'hED) hi = 8'h9F;
        else if (lead == 8'hF0) lo = 8'h90;
        else if (lead == 8'hF4) hi = 8'h8F;
      end
      return (b >= lo) && (b <= hi);
    end
  endfunction

  // windows-1251 bytes 0x80..0xbf of the high half; zero means no entry
  function automatic logic [15:0] hi_cp(input logic [5:0] i);
    logic [15:0] c;
    begin
      case (i)
        6'd0: c = 16'h0402;  6'd1: c = 16'h0403;  6'd2: c = 16'h201A;  6'd3: c = 16'h0453;
        6'd4: c = 16'h201E;  6'd5: c = 16'h2026;  6'd6: c = 16'h2020;  6'd7: c = 16'h2021;
        6'd8: c = 16'h20AC;  6'd9: c = 16'h2030;  6'd10: c = 16'h0409; 6'd11: c = 16'h2039;
        6'd12: c = 16'h040A; 6'd13: c = 16'h040C; 6'd14: c = 16'h040B; 6'd15: c = 16'h040F;
        6'd16: c = 16'h0452; 6'd17: c = 16'h2018; 6'd18: c = 16'h2019; 6'd19: c = 16'h201C;
        6'd20: c = 16'h201D; 6'd21: c = 16'h2022; 6'd22: c = 16'h2013; 6'd23: c = 16'h2014;
        6'd25: c = 16'h2122; 6'd26: c = 16'h0459; 6'd27: c = 16'h203A;
        6'd28: c = 16'h045A; 6'd29: c = 16'h045C; 6'd30: c = 16'h045B; 6'd31: c = 16'h045F;
        6'd33: c = 16'h040E; 6'd34: c = 16'h045E; 6'd35: c = 16'h0408;
        6'd36: c = 16'h00A4; 6'd37: c = 16'h0490; 6'd38: c = 16'h00A6; 6'd39: c = 16'h00A7;
        6'd40: c = 16'h0401; 6'd41: c = 16'h00A9; 6'd42: c = 16'h0404; 6'd43: c = 16'h00AB;
        6'd44: c = 16'h00AC; 6'd46: c = 16'h00AE; 6'd47: c = 16'h0407;
        6'd48: c = 16'h00B0; 6'd49: c = 16'h00B1; 6'd50: c = 16'h0406; 6'd51: c = 16'h0456;
        6'd52: c = 16'h0491; 6'd53: c = 16'h00B5; 6'd54: c = 16'h00B6; 6'd55: c = 16'h00B7;
        6'd56: c = 16'h0451; 6'd57: c = 16'h2116; 6'd58: c = 16'h0454; 6'd59: c = 16'h00BB;
        6'd60: c = 16'h0458; 6'd61: c = 16'h0405; 6'd62: c = 16'h0455; 6'd63: c = 16'h0457;
        default: c = 16'h0000;
      endcase
      return c;
    end
  endfunction

  function automatic logic [7:0] map_cp(input logic [20:0] cp);
    logic [7:0] r;
    logic [20:0] d;
    begin
      r = QmarkByte;
      d = cp - 21'h410;
      if (cp == 21'h0A || cp == 21'h0D) r = cp[7:0];
      else if (cp == 21'h09 || cp == 21'hA0) r = 8'h20;
      else if (cp >= 21'h20 && cp <= 21'h7E) r = cp[7:0];
      else if (cp >= 21'h410 && cp <= 21'h44F) r = {2'b11, d[5:0]};
      else if (cp == 21'hAD || cp == 21'h2212) r = 8'h2D;
      else if (cp >= 21'h80 && cp[20:16] == 5'd0) begin
        for (int i = 0; i < 64; i++) begin
          if (hi_cp(6'(i)) == cp[15:0]) r = {2'b10, 6'(i)};
        end
      end
      return r;
    end
  endfunction
endpackage
`default_nettype wire

FILE: rtl/utf8_to_cp1251_transcoder.sv
// utf-8 to windows-1251 transcoder, top level with sequencer and output register
// depends on u2c_pkg and u2c_decode
`timescale 1ns / 1ps
`default_nettype none
// one input byte is appended to up to three pending bytes, then a shared decode
// unit walks that buffer one sequence per cycle while the output register can
// take a result, each emitted sequence putting one result into the output
// register (up to four per item). s_axis_tready is high only in the idle state.
// a malformed sequence, or one cut off at end of text, emits its lead raw with
// from_invalid set and the following bytes are walked again; a sequence cut
// off before end of text is kept pending for the next byte.
module utf8_to_cp1251_transcoder import u2c_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,  // [7:0] in_byte
  input  wire logic       s_axis_tlast,  // end_of_text
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,  // [7:0] out_byte
  output logic [1:0]      m_axis_tuser,  // [0] from_invalid, [1] text_done
  output logic            m_axis_tlast   // run_last
);
  localparam logic [0:0] StIdle = 1'b0;
  localparam logic [0:0] StWalk = 1'b1;

  logic [0:0]  state_q, state_d;
  logic [31:0] buf_q, buf_d;     // byte 0 at the cursor
  logic [2:0]  avail_q, avail_d; // bytes left from the cursor
  logic [1:0]  pend_q, pend_d;
  logic        eot_q, eot_d;
  logic        ov_q, ov_d;
  u2c_res_t    res_q, res_d;
  logic        hold, inv;
  logic [7:0]  obyte;
  logic [2:0]  adv;
  logic [2:0]  left;

  u2c_decode u_dec (
    .buf_i(buf_q), .avail_i(avail_q), .eot_i(eot_q),
    .hold_o(hold), .byte_o(obyte), .inv_o(inv), .adv_o(adv)
  );

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = res_q.out_byte;
  assign m_axis_tuser  = {res_q.text_done, res_q.from_invalid};
  assign m_axis_tlast  = res_q.run_last;
  assign left = avail_q - adv;

  always_comb begin
    state_d = state_q;
    buf_d   = buf_q;
    avail_d = avail_q;
    pend_d  = pend_q;
    eot_d   = eot_q;
    ov_d    = ov_q && !m_axis_tready;
    res_d   = res_q;
    case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          // append the new byte behind the pending ones
          buf_d = buf_q;
          buf_d[8*pend_q +: 8] = s_axis_tdata;
          avail_d = 3'(pend_q) + 3'd1;
          eot_d   = s_axis_tlast;
          state_d = StWalk;
        end
      end
      StWalk: begin
        if (hold) begin
          pend_d  = avail_q[1:0];
          state_d = StIdle;
        end else if (!ov_q || m_axis_tready) begin
          ov_d = 1'b1;
          res_d.out_byte     = obyte;
          res_d.from_invalid = inv;
          res_d.run_last     = (left == 3'd0) || (!eot_q && left < 3'd4 &&
                               seq_length(buf_q[8*adv[1:0] +: 8]) > left &&
                               seq_length(buf_q[8*adv[1:0] +: 8]) != 3'd0 &&
                               (left < 3'd2 || follow_ok(buf_q[8*adv[1:0] +: 8], 2'd1,
                                buf_q[8*(adv[1:0]+2'd1) +: 8])) &&
                               (left < 3'd3 || follow_ok(buf_q[8*adv[1:0] +: 8], 2'd2,
                                buf_q[8*(adv[1:0]+2'd2) +: 8])));
          res_d.text_done    = eot_q && (left == 3'd0);
          buf_d   = buf_q >> {adv, 3'b000};
          avail_d = left;
          if (left == 3'd0) begin
            pend_d  = 2'd0;
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      pend_q  <= 2'd0;
      avail_q <= 3'd0;
      eot_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      avail_q <= avail_d;
      eot_q   <= eot_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
    res_q <= res_d;
  end
endmodule
`default_nettype wire

FILE: rtl/u2c_decode.sv
// shared decode unit: classifies the sequence at one buffer position
// depends on u2c_pkg
`timescale 1ns / 1ps
`default_nettype none
module u2c_decode import u2c_pkg::*; (
  input  wire logic [31:0] buf_i,   // four bytes from the cursor, cursor byte lowest
  input  wire logic [2:0]  avail_i, // bytes available from the cursor
  input  wire logic        eot_i,
  output logic             hold_o,  // keep the remaining bytes pending
  output logic [7:0]       byte_o,
  output logic             inv_o,
  output logic [2:0]       adv_o
);
  logic [7:0] lead;
  logic [2:0] len;
  logic       ok;
  logic [20:0] cp;

  assign lead = buf_i[7:0];
  assign len  = seq_length(lead);

  always_comb begin
    ok = 1'b1;
    for (int i = 1; i < 4; i++) begin
      if (3'(i) < len && 3'(i) < avail_i && !follow_ok(lead, 2'(i), buf_i[8*i +: 8]))
        ok = 1'b0;
    end
    case (len)
      3'd2: cp = {10'd0, lead[4:0], buf_i[13:8]};
      3'd3: cp = {5'd0, lead[3:0], buf_i[13:8], buf_i[21:16]};
      3'd4: cp = {lead[2:0], buf_i[13:8], buf_i[21:16], buf_i[29:24]};
      default: cp = {13'd0, lead};
    endcase
    hold_o = 1'b0;
    if (len == 3'd1) begin
      byte_o = map_cp(cp);
      inv_o  = 1'b0;
      adv_o  = 3'd1;
    end else if (len == 3'd0 || !ok || avail_i < len) begin
      hold_o = (len != 3'd0) && ok && !eot_i;
      byte_o = lead;
      inv_o  = 1'b1;
      adv_o  = 3'd1;
    end else begin
      byte_o = map_cp(cp);
      inv_o  = 1'b0;
      adv_o  = len;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/u2c_checker.sv
// port-level checker for the transcoder, bound to the top level
// depends on utf8_to_cp1251_transcoder_assert.svh
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_to_cp1251_transcoder_assert.svh"
module u2c_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       s_axis_tvalid,
  input wire logic       s_axis_tready,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic [1:0] m_axis_tuser,
  input wire logic       m_axis_tlast
);
  // text done only on the last result of an item
  `U2C_ASSERT_IMP(a_done_last, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[1], m_axis_tlast)
  // a stalled result holds its payload
  `U2C_ASSERT_NXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
  // an accepted item closes input for the next cycle
  `U2C_ASSERT_NXT(a_busy, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)
endmodule
bind utf8_to_cp1251_transcoder u2c_checker u_chk (.*);
`default_nettype wire
